>>> sv/bapf_pkg.sv
// Package for the box adjacency pair finder: shared types, defaults and register indexes.
// No dependencies; every other file of the block refers to it by scoped names.
package bapf_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_BOXES_DEF   = 64;
	localparam int MAX_DIMS_DEF    = 8;
	localparam int COORD_WIDTH_DEF = 32;

	// Fixed field widths of the ports
	localparam int DIM_IDX_W = 3;
	localparam int BOX_IDX_W = 6;
	localparam int TOL_W     = 31;
	localparam int NDIMS_W   = 4;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 31;

	// Depth of the queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DIMS      = 1'd1;

	// Reset values of the configuration registers
	localparam logic [TOL_W-1:0]   TOLERANCE_RST = '0;
	localparam logic [NDIMS_W-1:0] DIMS_RST      = 4'd7;

	// Control part of a queued item, classified by the front
	typedef struct packed {
		logic                 new_set;
		logic                 dim_ok;
		logic [DIM_IDX_W-1:0] dim_index;
		logic                 box_complete;
	} ctl_t;

	// Walk token carried down the compare pipeline
	typedef struct packed {
		logic                 valid;
		logic                 is_end;
		logic                 full;
		logic                 first;
		logic                 last;
		logic [BOX_IDX_W-1:0] j;
		logic [BOX_IDX_W-1:0] cur;
	} tok_t;

	// One result item
	typedef struct packed {
		logic                 pair_valid;
		logic [BOX_IDX_W-1:0] earlier_box;
		logic [BOX_IDX_W-1:0] new_box;
		logic                 last_of_run;
		logic                 store_full;
	} res_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_WALK,
		BK_END
	} back_state_t;

endpackage

>>> sv/bapf_front.sv
// Front of the pair finder: input register that takes items and classifies them.
// Depends on bapf_pkg; feeds bapf_queue.
module bapf_front #(
	parameter int MAX_DIMS    = bapf_pkg::MAX_DIMS_DEF,
	parameter int COORD_WIDTH = bapf_pkg::COORD_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               new_set,
	input  logic [bapf_pkg::DIM_IDX_W-1:0]     dim_index,
	input  logic signed [COORD_WIDTH-1:0]      lower_bound,
	input  logic signed [COORD_WIDTH-1:0]      upper_bound,
	input  logic                               box_complete,
	input  logic                               q_full,
	output logic                               q_push,
	output bapf_pkg::ctl_t                     q_ctl,
	output logic [COORD_WIDTH-1:0]             q_lower,
	output logic [COORD_WIDTH-1:0]             q_upper
);

	logic           entry_valid_q;
	bapf_pkg::ctl_t ctl_q;
	logic [COORD_WIDTH-1:0] lower_q;
	logic [COORD_WIDTH-1:0] upper_q;
	logic           accept;
	logic           dim_ok;

	assign in_stall = entry_valid_q && q_full;
	assign accept   = in_valid && !in_stall;
	assign q_push   = entry_valid_q && !q_full;
	assign dim_ok   = 32'(dim_index) < 32'(MAX_DIMS);

	assign q_ctl   = ctl_q;
	assign q_lower = lower_q;
	assign q_upper = upper_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= 1'b0;
		end else if (accept) begin
			entry_valid_q <= 1'b1;
		end else if (q_push) begin
			entry_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_q.new_set      <= new_set;
			ctl_q.dim_ok       <= dim_ok;
			ctl_q.dim_index    <= dim_index;
			ctl_q.box_complete <= box_complete;
			lower_q            <= lower_bound;
			upper_q            <= upper_bound;
		end
	end

endmodule

>>> sv/bapf_queue.sv
// Short queue between the front and the back of the pair finder.
// Depends on bapf_pkg for nothing but the default depth; generic data word.
module bapf_queue #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = bapf_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	output logic              valid,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full     = count_q == CNT_W'(DEPTH);
	assign valid    = count_q != '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && valid;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + CNT_W'(1);
				2'b01:   count_q <= count_q - CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

>>> sv/bapf_back.sv
// Back of the pair finder: bound store, walk sequencer, compare pipeline and output register.
// Depends on bapf_pkg; takes items from bapf_queue.
module bapf_back #(
	parameter int MAX_BOXES   = bapf_pkg::MAX_BOXES_DEF,
	parameter int MAX_DIMS    = bapf_pkg::MAX_DIMS_DEF,
	parameter int COORD_WIDTH = bapf_pkg::COORD_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	input  bapf_pkg::ctl_t                   q_ctl,
	input  logic [COORD_WIDTH-1:0]           q_lower,
	input  logic [COORD_WIDTH-1:0]           q_upper,
	output logic                             q_pop,
	input  logic [bapf_pkg::TOL_W-1:0]       tolerance,
	input  logic [bapf_pkg::NDIMS_W-1:0]     dims_in_use,
	output logic                             out_valid,
	output bapf_pkg::res_t                   out_res,
	input  logic                             out_stall
);

	localparam int BOX_W  = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CNT_W  = $clog2(MAX_BOXES + 1);
	localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int ND_W   = $clog2(MAX_DIMS + 1);
	localparam int ADDR_W = BOX_W + DIM_W;
	localparam int DEPTH  = MAX_BOXES << DIM_W;
	localparam int DW     = COORD_WIDTH + 1;
	localparam int EW     = ((DW > bapf_pkg::TOL_W + 1) ? DW : bapf_pkg::TOL_W + 1) + 1;
	localparam int IW     = bapf_pkg::BOX_IDX_W;

	bapf_pkg::back_state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q, count_d, eff_count;
	logic [BOX_W-1:0]  cur_q, cur_d, j_q, j_d;
	logic [DIM_W-1:0]  d_q, d_d;
	logic [ND_W-1:0]   nd_q, nd_d, nd_clamp;
	logic              adv, has_room, mem_we, d_last, j_last;
	logic [ADDR_W-1:0] waddr;

	bapf_pkg::tok_t iss_tok, tok_s1, tok_s2, tok_s3, tok_s4;

	logic [COORD_WIDTH-1:0] lo_mem [DEPTH];
	logic [COORD_WIDTH-1:0] hi_mem [DEPTH];

	logic signed [COORD_WIDTH-1:0] lo_cur_s1, lo_oth_s1, hi_cur_s1, hi_oth_s1;
	logic signed [COORD_WIDTH-1:0] mh_s2, ml_s2;
	logic signed [DW-1:0]          diff_s3;
	logic signed [EW-1:0]          diff_ext, tol_ext, sum_a, sum_b;
	logic                          na_s4, tc_s4;
	logic                          acc_adj_q, acc_tc_q, adj_now, tc_now;
	logic                          emit_pair, emit_end;
	logic                          out_valid_q;
	bapf_pkg::res_t                out_res_q;

	assign adv       = !out_valid_q || !out_stall;
	assign eff_count = q_ctl.new_set ? '0 : count_q;
	assign has_room  = eff_count < CNT_W'(MAX_BOXES);
	assign waddr     = {eff_count[BOX_W-1:0], DIM_W'(q_ctl.dim_index)};
	assign d_last    = ND_W'(d_q) == nd_q - ND_W'(1);
	assign j_last    = j_q == cur_q - BOX_W'(1);

	// zero acts as one dimension, anything above the store's width as the full width
	assign nd_clamp = (dims_in_use == '0) ? ND_W'(1) :
		(32'(dims_in_use) > 32'(MAX_DIMS)) ? ND_W'(MAX_DIMS) : ND_W'(dims_in_use);

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		cur_d   = cur_q;
		j_d     = j_q;
		d_d     = d_q;
		nd_d    = nd_q;
		q_pop   = 1'b0;
		mem_we  = 1'b0;
		iss_tok = '0;
		if (adv) begin
			unique case (state_q)
				bapf_pkg::BK_IDLE: begin
					if (q_valid) begin
						q_pop   = 1'b1;
						mem_we  = has_room && q_ctl.dim_ok;
						count_d = eff_count;
						if (q_ctl.box_complete) begin
							if (!has_room) begin
								iss_tok.valid  = 1'b1;
								iss_tok.is_end = 1'b1;
								iss_tok.full   = 1'b1;
							end else if (eff_count == '0) begin
								iss_tok.valid  = 1'b1;
								iss_tok.is_end = 1'b1;
								count_d        = CNT_W'(1);
							end else begin
								cur_d   = eff_count[BOX_W-1:0];
								j_d     = '0;
								d_d     = '0;
								nd_d    = nd_clamp;
								count_d = eff_count + CNT_W'(1);
								state_d = bapf_pkg::BK_WALK;
							end
						end
					end
				end
				bapf_pkg::BK_WALK: begin
					iss_tok.valid = 1'b1;
					iss_tok.first = d_q == '0;
					iss_tok.last  = d_last;
					iss_tok.j     = IW'(j_q);
					iss_tok.cur   = IW'(cur_q);
					if (d_last) begin
						d_d = '0;
						if (j_last) begin
							state_d = bapf_pkg::BK_END;
						end else begin
							j_d = j_q + BOX_W'(1);
						end
					end else begin
						d_d = d_q + DIM_W'(1);
					end
				end
				bapf_pkg::BK_END: begin
					iss_tok.valid  = 1'b1;
					iss_tok.is_end = 1'b1;
					iss_tok.cur    = IW'(cur_q);
					state_d        = bapf_pkg::BK_IDLE;
				end
				default: state_d = bapf_pkg::BK_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bapf_pkg::BK_IDLE;
			count_q <= '0;
			cur_q   <= '0;
			j_q     <= '0;
			d_q     <= '0;
			nd_q    <= ND_W'(1);
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			cur_q   <= cur_d;
			j_q     <= j_d;
			d_q     <= d_d;
			nd_q    <= nd_d;
		end
	end

	// Bound store: one write port, reads of the new box's row and the stored row
	always_ff @(posedge clk) begin
		if (mem_we) begin
			lo_mem[waddr] <= q_lower;
			hi_mem[waddr] <= q_upper;
		end
		if (adv) begin
			lo_cur_s1 <= lo_mem[{cur_q, d_q}];
			hi_cur_s1 <= hi_mem[{cur_q, d_q}];
			lo_oth_s1 <= lo_mem[{j_q, d_q}];
			hi_oth_s1 <= hi_mem[{j_q, d_q}];
		end
	end

	// The whole pipeline holds while the output register cannot take a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
			tok_s3 <= '0;
			tok_s4 <= '0;
		end else if (adv) begin
			tok_s1 <= iss_tok;
			tok_s2 <= tok_s1;
			tok_s3 <= tok_s2;
			tok_s4 <= tok_s3;
		end
	end

	assign diff_ext = EW'(diff_s3);
	assign tol_ext  = EW'({1'b0, tolerance});
	assign sum_a    = diff_ext + tol_ext;
	assign sum_b    = diff_ext - tol_ext;

	always_ff @(posedge clk) begin
		if (adv) begin
			mh_s2   <= (hi_cur_s1 < hi_oth_s1) ? hi_cur_s1 : hi_oth_s1;
			ml_s2   <= (lo_cur_s1 > lo_oth_s1) ? lo_cur_s1 : lo_oth_s1;
			diff_s3 <= DW'(mh_s2) - DW'(ml_s2);
			na_s4   <= !sum_a[EW-1];
			tc_s4   <= sum_b[EW-1] || (sum_b == '0);
		end
	end

	assign adj_now   = tok_s4.first ? na_s4 : (acc_adj_q && na_s4);
	assign tc_now    = tok_s4.first ? tc_s4 : (acc_tc_q || tc_s4);
	assign emit_pair = tok_s4.valid && !tok_s4.is_end && tok_s4.last && adj_now && tc_now;
	assign emit_end  = tok_s4.valid && tok_s4.is_end;

	always_ff @(posedge clk) begin
		if (adv && tok_s4.valid && !tok_s4.is_end) begin
			acc_adj_q <= adj_now;
			acc_tc_q  <= tc_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= emit_pair || emit_end;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit_pair) begin
			out_res_q.pair_valid  <= 1'b1;
			out_res_q.earlier_box <= tok_s4.j;
			out_res_q.new_box     <= tok_s4.cur;
			out_res_q.last_of_run <= 1'b0;
			out_res_q.store_full  <= 1'b0;
		end else if (adv && emit_end) begin
			out_res_q.pair_valid  <= 1'b0;
			out_res_q.earlier_box <= '0;
			out_res_q.new_box     <= tok_s4.cur;
			out_res_q.last_of_run <= 1'b1;
			out_res_q.store_full  <= tok_s4.full;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

endmodule

>>> sv/box_adjacency_pair_finder_unit.sv
// Box adjacency pair finder. Boxes arrive one dimension per transfer; the transfer that marks
// a box complete compares it with every stored box. An item that does not complete a box
// is registered by the front, held in the queue and written to the bound store once the
// back takes it. A completing box walks each stored box-dimension pair, reading one pair per
// cycle from the two-port bound store while the output is not stalled; the pairs and end
// marker pass through compare stages tok_s1 to tok_s4 and the output register. A full or
// empty store gives the end marker without a walk. The store needs no clearing pass; a new
// set only resets the box count. Depends on bapf_pkg, bapf_front, bapf_queue and bapf_back.
module box_adjacency_pair_finder_unit #(
	parameter int MAX_BOXES   = bapf_pkg::MAX_BOXES_DEF,
	parameter int MAX_DIMS    = bapf_pkg::MAX_DIMS_DEF,
	parameter int COORD_WIDTH = bapf_pkg::COORD_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bapf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bapf_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               new_set,
	input  logic [bapf_pkg::DIM_IDX_W-1:0]     dim_index,
	input  logic signed [COORD_WIDTH-1:0]      lower_bound,
	input  logic signed [COORD_WIDTH-1:0]      upper_bound,
	input  logic                               box_complete,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               pair_valid,
	output logic [bapf_pkg::BOX_IDX_W-1:0]     earlier_box,
	output logic [bapf_pkg::BOX_IDX_W-1:0]     new_box,
	output logic                               last_of_run,
	output logic                               store_full
);

	localparam int CTL_W  = $bits(bapf_pkg::ctl_t);
	localparam int DATA_W = CTL_W + 2 * COORD_WIDTH;

	logic [bapf_pkg::TOL_W-1:0]   tolerance_q;
	logic [bapf_pkg::NDIMS_W-1:0] dims_q;

	logic                   f_push, q_full, q_valid, q_pop;
	bapf_pkg::ctl_t         f_ctl, b_ctl;
	logic [COORD_WIDTH-1:0] f_lower, f_upper, b_lower, b_upper;
	logic [DATA_W-1:0]      q_out;
	bapf_pkg::res_t         res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= bapf_pkg::TOLERANCE_RST;
			dims_q      <= bapf_pkg::DIMS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bapf_pkg::CFG_TOLERANCE: tolerance_q <= cfg_data[bapf_pkg::TOL_W-1:0];
				bapf_pkg::CFG_DIMS:      dims_q      <= cfg_data[bapf_pkg::NDIMS_W-1:0];
				default:                 dims_q      <= dims_q;
			endcase
		end
	end

	bapf_front #(
		.MAX_DIMS    (MAX_DIMS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.new_set      (new_set),
		.dim_index    (dim_index),
		.lower_bound  (lower_bound),
		.upper_bound  (upper_bound),
		.box_complete (box_complete),
		.q_full       (q_full),
		.q_push       (f_push),
		.q_ctl        (f_ctl),
		.q_lower      (f_lower),
		.q_upper      (f_upper)
	);

	bapf_queue #(
		.DATA_W (DATA_W),
		.DEPTH  (bapf_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_data ({f_ctl, f_lower, f_upper}),
		.full      (q_full),
		.valid     (q_valid),
		.pop       (q_pop),
		.pop_data  (q_out)
	);

	assign {b_ctl, b_lower, b_upper} = q_out;

	bapf_back #(
		.MAX_BOXES   (MAX_BOXES),
		.MAX_DIMS    (MAX_DIMS),
		.COORD_WIDTH (COORD_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_ctl       (b_ctl),
		.q_lower     (b_lower),
		.q_upper     (b_upper),
		.q_pop       (q_pop),
		.tolerance   (tolerance_q),
		.dims_in_use (dims_q),
		.out_valid   (out_valid),
		.out_res     (res),
		.out_stall   (out_stall)
	);

	assign pair_valid  = res.pair_valid;
	assign earlier_box = res.earlier_box;
	assign new_box     = res.new_box;
	assign last_of_run = res.last_of_run;
	assign store_full  = res.store_full;

endmodule

>>> sv/bapf_checker.sv
// Port-level checks for the pair finder, bound to the top level.
// Depends on bapf_pkg and box_adjacency_pair_finder_unit.
module bapf_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic                           pair_valid,
	input logic [bapf_pkg::BOX_IDX_W-1:0] earlier_box,
	input logic [bapf_pkg::BOX_IDX_W-1:0] new_box,
	input logic                           last_of_run,
	input logic                           store_full
);

	// A result waiting on a stall stays put
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pair_valid) && $stable(earlier_box)
			&& $stable(new_box) && $stable(last_of_run) && $stable(store_full))
		else $error("stalled result changed");

	// The end marker is never a pair
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pair_valid != last_of_run))
		else $error("result is both pair and end marker, or neither");

	// A refused box gives a bare end marker
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && store_full |-> last_of_run && new_box == '0 && earlier_box == '0)
		else $error("refusal not reported as bare end marker");

	// Pairs name an earlier box first
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pair_valid |-> earlier_box < new_box && !store_full)
		else $error("pair out of canonical order");

	// Once a pair is taken, the next result belongs to the same new box
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && pair_valid ##1 out_valid |-> new_box == $past(new_box))
		else $error("run of pairs broken before its end marker");

endmodule

bind box_adjacency_pair_finder_unit bapf_checker u_bapf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.pair_valid  (pair_valid),
	.earlier_box (earlier_box),
	.new_box     (new_box),
	.last_of_run (last_of_run),
	.store_full  (store_full)
);
